/* sv/dsfp_pkg.sv */
// Shared types and constants for the dust sensor frame parser.
// Used by every module of the block; depends on nothing else.
package dsfp_pkg;

   // Default frame length in bytes, markers included.
   localparam int FRAME_BYTES_DEFAULT = 32;
   // Default depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] MARK_FIRST  = 8'h42;
   localparam logic [7:0] MARK_SECOND = 8'h4D;
   localparam logic [7:0] LEN_HIGH    = 8'h00;
   localparam logic [7:0] LEN_LOW     = 8'h1C;

   // Byte positions within a frame.
   localparam int POS_SECOND_MARK = 1;
   localparam int POS_LEN_HIGH    = 2;
   localparam int POS_LEN_LOW     = 3;
   localparam int POS_SMALL_HIGH  = 4;
   localparam int POS_SMALL_LOW   = 5;
   localparam int POS_FINE_HIGH   = 6;
   localparam int POS_FINE_LOW    = 7;
   localparam int POS_COARSE_HIGH = 8;
   localparam int POS_COARSE_LOW  = 9;

   // What the back part does with one classified byte.
   typedef enum logic [3:0] {
      OP_START,
      OP_SUM,
      OP_LEN_HIGH,
      OP_LEN_LOW,
      OP_SMALL,
      OP_FINE,
      OP_COARSE,
      OP_SUM_HIGH,
      OP_FINAL
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK       = 2'd0,
      ERR_LENGTH   = 2'd1,
      ERR_CHECKSUM = 2'd2
   } err_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } item_type;

endpackage

/* sv/dsfp_front.sv */
// Front part of the frame parser: accepts bytes, tracks the frame position
// and tags each kept byte with its operation. Depends on dsfp_pkg.
module dsfp_front #(
   parameter int FRAME_BYTES = dsfp_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               push_valid,
   input  logic               push_ready,
   output dsfp_pkg::item_type push_item
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam logic [IDX_W-1:0] IDX_ZERO   = '0;
   localparam logic [IDX_W-1:0] IDX_SECOND = IDX_W'(dsfp_pkg::POS_SECOND_MARK);
   localparam logic [IDX_W-1:0] IDX_SUMHI  = IDX_W'(FRAME_BYTES - 2);
   localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_BYTES - 1);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept;
   logic             keep;
   dsfp_pkg::op_type op;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      idx_in = idx_ff;
      keep   = 1'b0;
      op     = dsfp_pkg::OP_SUM;
      if (idx_ff == IDX_ZERO) begin
         if (req_rx_byte == dsfp_pkg::MARK_FIRST) begin
            keep   = 1'b1;
            op     = dsfp_pkg::OP_START;
            idx_in = IDX_SECOND;
         end
      end else if (idx_ff == IDX_SECOND) begin
         if (req_rx_byte == dsfp_pkg::MARK_SECOND) begin
            keep   = 1'b1;
            op     = dsfp_pkg::OP_SUM;
            idx_in = idx_ff + 1'b1;
         end else if (req_rx_byte == dsfp_pkg::MARK_FIRST) begin
            // A wrong second marker that is itself a first marker opens a new frame.
            keep   = 1'b1;
            op     = dsfp_pkg::OP_START;
            idx_in = IDX_SECOND;
         end else begin
            idx_in = IDX_ZERO;
         end
      end else begin
         keep   = 1'b1;
         idx_in = idx_ff + 1'b1;
         if (idx_ff == IDX_LAST) begin
            op     = dsfp_pkg::OP_FINAL;
            idx_in = IDX_ZERO;
         end else if (idx_ff == IDX_SUMHI) begin
            op = dsfp_pkg::OP_SUM_HIGH;
         end else if (idx_ff == IDX_W'(dsfp_pkg::POS_LEN_HIGH)) begin
            op = dsfp_pkg::OP_LEN_HIGH;
         end else if (idx_ff == IDX_W'(dsfp_pkg::POS_LEN_LOW)) begin
            op = dsfp_pkg::OP_LEN_LOW;
         end else if (idx_ff inside {IDX_W'(dsfp_pkg::POS_SMALL_HIGH),
                                     IDX_W'(dsfp_pkg::POS_SMALL_LOW)}) begin
            op = dsfp_pkg::OP_SMALL;
         end else if (idx_ff inside {IDX_W'(dsfp_pkg::POS_FINE_HIGH),
                                     IDX_W'(dsfp_pkg::POS_FINE_LOW)}) begin
            op = dsfp_pkg::OP_FINE;
         end else if (idx_ff inside {IDX_W'(dsfp_pkg::POS_COARSE_HIGH),
                                     IDX_W'(dsfp_pkg::POS_COARSE_LOW)}) begin
            op = dsfp_pkg::OP_COARSE;
         end
      end
   end

   assign push_valid     = accept && keep;
   assign push_item.op   = op;
   assign push_item.data = req_rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= IDX_ZERO;
      end else if (accept) begin
         idx_ff <= idx_in;
      end
   end

   // A byte is kept only when the queue can take it.
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("front pushed a byte into a full queue");

endmodule

/* sv/dsfp_queue.sv */
// Short queue of classified bytes between the front and back parts.
// Depends on dsfp_pkg for the item type.
module dsfp_queue #(
   parameter int DEPTH = dsfp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dsfp_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output dsfp_pkg::item_type out_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   dsfp_pkg::item_type mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_item  = mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond its depth");

endmodule

/* sv/dsfp_back.sv */
// Back part of the frame parser: applies classified bytes to the checksum,
// length check and concentration words, and registers the frame result.
// Depends on dsfp_pkg.
module dsfp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  dsfp_pkg::item_type pop_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_frame_ok,
   output logic [1:0]         rsp_error_code,
   output logic [15:0]        rsp_pm_small,
   output logic [15:0]        rsp_pm_fine,
   output logic [15:0]        rsp_pm_coarse
);

   logic [15:0] sum_ff, sum_in;
   logic        len_good_ff, len_good_in;
   logic [7:0]  sum_high_ff, sum_high_in;
   logic [15:0] small_ff, small_in;
   logic [15:0] fine_ff, fine_in;
   logic [15:0] coarse_ff, coarse_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [1:0]  rsp_err_ff, rsp_err_in;
   logic [15:0] rsp_small_ff, rsp_small_in;
   logic [15:0] rsp_fine_ff, rsp_fine_in;
   logic [15:0] rsp_coarse_ff, rsp_coarse_in;

   logic              is_final;
   logic              pop;
   logic [15:0]       sum_add;
   logic [15:0]       given;
   dsfp_pkg::err_type err;

   // Only the final byte needs the result register; other bytes flow on.
   assign is_final  = (pop_item.op == dsfp_pkg::OP_FINAL);
   assign pop_ready = !is_final || !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;
   assign sum_add   = sum_ff + {8'h00, pop_item.data};
   assign given     = {sum_high_ff, pop_item.data};

   always_comb begin
      if (!len_good_ff) begin
         err = dsfp_pkg::ERR_LENGTH;
      end else if (given != sum_ff) begin
         err = dsfp_pkg::ERR_CHECKSUM;
      end else begin
         err = dsfp_pkg::ERR_OK;
      end
   end

   always_comb begin
      sum_in      = sum_ff;
      len_good_in = len_good_ff;
      sum_high_in = sum_high_ff;
      small_in    = small_ff;
      fine_in     = fine_ff;
      coarse_in   = coarse_ff;
      if (pop) begin
         case (pop_item.op)
            dsfp_pkg::OP_START: begin
               sum_in      = {8'h00, dsfp_pkg::MARK_FIRST};
               len_good_in = 1'b1;
            end
            dsfp_pkg::OP_SUM: begin
               sum_in = sum_add;
            end
            dsfp_pkg::OP_LEN_HIGH: begin
               sum_in = sum_add;
               if (pop_item.data != dsfp_pkg::LEN_HIGH) begin
                  len_good_in = 1'b0;
               end
            end
            dsfp_pkg::OP_LEN_LOW: begin
               sum_in = sum_add;
               if (pop_item.data != dsfp_pkg::LEN_LOW) begin
                  len_good_in = 1'b0;
               end
            end
            dsfp_pkg::OP_SMALL: begin
               sum_in   = sum_add;
               small_in = {small_ff[7:0], pop_item.data};
            end
            dsfp_pkg::OP_FINE: begin
               sum_in  = sum_add;
               fine_in = {fine_ff[7:0], pop_item.data};
            end
            dsfp_pkg::OP_COARSE: begin
               sum_in    = sum_add;
               coarse_in = {coarse_ff[7:0], pop_item.data};
            end
            dsfp_pkg::OP_SUM_HIGH: begin
               sum_high_in = pop_item.data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_small_in  = rsp_small_ff;
      rsp_fine_in   = rsp_fine_ff;
      rsp_coarse_in = rsp_coarse_ff;
      if (pop && is_final) begin
         rsp_valid_in  = 1'b1;
         rsp_ok_in     = (err == dsfp_pkg::ERR_OK);
         rsp_err_in    = err;
         rsp_small_in  = (err == dsfp_pkg::ERR_OK) ? small_ff : 16'h0000;
         rsp_fine_in   = (err == dsfp_pkg::ERR_OK) ? fine_ff : 16'h0000;
         rsp_coarse_in = (err == dsfp_pkg::ERR_OK) ? coarse_ff : 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         len_good_ff  <= 1'b1;
         sum_high_ff  <= '0;
         small_ff     <= '0;
         fine_ff      <= '0;
         coarse_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         len_good_ff  <= len_good_in;
         sum_high_ff  <= sum_high_in;
         small_ff     <= small_in;
         fine_ff      <= fine_in;
         coarse_ff    <= coarse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff     <= rsp_ok_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_small_ff  <= rsp_small_in;
      rsp_fine_ff   <= rsp_fine_in;
      rsp_coarse_ff <= rsp_coarse_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_ok   = rsp_ok_ff;
   assign rsp_error_code = rsp_err_ff;
   assign rsp_pm_small   = rsp_small_ff;
   assign rsp_pm_fine    = rsp_fine_ff;
   assign rsp_pm_coarse  = rsp_coarse_ff;

   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ok_ff == (rsp_err_ff == dsfp_pkg::ERR_OK)))
      else $error("frame_ok disagrees with error_code");

   a_error_clears_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff != dsfp_pkg::ERR_OK) |->
         (rsp_small_ff == 16'h0000 && rsp_fine_ff == 16'h0000 &&
          rsp_coarse_ff == 16'h0000))
      else $error("failed frame carries concentration words");

endmodule

/* sv/dust_sensor_frame_parser.sv */
// Top level of the dust sensor frame parser: front classifier, byte queue
// and back executor. Depends on dsfp_pkg, dsfp_front, dsfp_queue, dsfp_back.
//
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   req_rx_byte (one serial byte)
// rsp_      out        rsp_valid/rsp_ready   rsp_frame_ok, rsp_error_code,
//                                            rsp_pm_small, rsp_pm_fine, rsp_pm_coarse
//
// One byte is accepted per cycle, sustained, as long as the result side keeps up.
// A frame's last byte is written into the queue when it is accepted; the back
// part then takes it from the queue and loads the result register, unless the
// result side is still holding an earlier result.
// Synchronous reset puts the front back into hunting for the start marker and
// empties the queue and the result register; no clearing pass is needed.
// A stalled result only holds back the back part when another frame's last
// byte reaches it; bytes keep flowing into the queue until it fills.
module dust_sensor_frame_parser #(
   parameter int FRAME_BYTES = dsfp_pkg::FRAME_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = dsfp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_ok,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_pm_small,
   output logic [15:0] rsp_pm_fine,
   output logic [15:0] rsp_pm_coarse
);

   // Classified byte transactions from the front part into the queue.
   logic               push_valid;
   logic               push_ready;
   dsfp_pkg::item_type push_item;

   // Queue output towards the back part.
   logic               pop_valid;
   logic               pop_ready;
   dsfp_pkg::item_type pop_item;

   // The front part tracks the frame position and drops bytes seen while
   // hunting, so the back part only sees bytes of a frame in progress.
   dsfp_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   dsfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_item  (pop_item)
   );

   // The back part keeps the running checksum, the length check and the
   // concentration words, and turns the last byte into a result transaction.
   dsfp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_ok   (rsp_frame_ok),
      .rsp_error_code (rsp_error_code),
      .rsp_pm_small   (rsp_pm_small),
      .rsp_pm_fine    (rsp_pm_fine),
      .rsp_pm_coarse  (rsp_pm_coarse)
   );

endmodule
